[rtl/t3ii_pkg.sv]
// Package for the 3x3 tensor invariants and inverse unit.
// Holds the mode codes, the pipeline control struct and the index tables; no dependencies.
package t3ii_pkg;

  typedef enum logic [1:0] {
    MODE_INVAR   = 2'd0,
    MODE_INVERSE = 2'd1,
    MODE_DEVIA   = 2'd2
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } t3ii_ctl_t;

  // Adjugate entry k is m[ADJ_IDX[k][0]]*m[ADJ_IDX[k][1]] - m[ADJ_IDX[k][2]]*m[ADJ_IDX[k][3]],
  // with entries numbered row-major.
  localparam logic [3:0] ADJ_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Row-major index of the transposed entry.
  localparam logic [3:0] TRN_IDX [9] = '{
    4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
  };

endpackage

[rtl/t3ii_front.sv]
// Front end of the tensor unit: products, adjugate, determinant, invariants and the
// deviatoric part, in five register stages. Depends on t3ii_pkg.
module t3ii_front #(
  parameter int D = 32,
  parameter int F = 16,
  localparam int AW = 2 * D + 1,
  localparam int DW = 3 * D + 3,
  localparam int NW = AW + 2 * F,
  localparam int CW = (NW > DW + D) ? NW : DW + D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  t3ii_pkg::t3ii_ctl_t  ctl_i,
  input  logic signed [D-1:0]  m_i [9],
  output t3ii_pkg::t3ii_ctl_t  ctl_o,
  output logic [CW-1:0]        rem_o [9],
  output logic [8:0]           neg_o,
  output logic [8:0]           qovf_o,
  output logic                 sing_o,
  output logic [DW-1:0]        dabs_o,
  output logic signed [D-1:0]  alt_o [9],
  output logic                 altovf_o
);
  import t3ii_pkg::*;

  localparam int PW   = 2 * D;
  localparam int SQW  = 2 * D + 4;
  localparam int I2W  = 2 * D + 5;
  localparam int TW   = D + 2;
  localparam int XW   = D + 1;
  localparam int K    = D + 3;
  localparam int WW   = DW;

  // floor(2^K / 3): the binary fraction 0.0101... scaled up.
  function automatic logic [K-1:0] third_recip();
    logic [K-1:0] r;
    r = '0;
    for (int i = 0; i < K; i++) begin
      r[i] = (i <= K - 2) && (((K - i) & 1) == 0);
    end
    return r;
  endfunction

  localparam logic [K-1:0] M3 = third_recip();

  // Returns {overflow, value} for a value clamped to the D-bit signed range.
  function automatic logic [D:0] sat_d(input logic signed [WW-1:0] x);
    logic [D:0] r;
    if ((~|x[WW-1:D-1]) || (&x[WW-1:D-1])) begin
      r = {1'b0, x[D-1:0]};
    end else if (x[WW-1]) begin
      r = {2'b11, {(D-1){1'b0}}};
    end else begin
      r = {2'b10, {(D-1){1'b1}}};
    end
    return r;
  endfunction

  // Stage A: pairwise products and trace.
  t3ii_ctl_t              ctl_a_r;
  logic signed [D-1:0]    m_a_r [9];
  logic signed [TW-1:0]   t_a_r;
  logic signed [PW-1:0]   pc0_a_r [9];
  logic signed [PW-1:0]   pc1_a_r [9];
  logic signed [PW-1:0]   ps_a_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r <= m_i;
      t_a_r <= TW'(m_i[0]) + TW'(m_i[4]) + TW'(m_i[8]);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        pc0_a_r[k] <= PW'(m_i[ADJ_IDX[k][0]]) * PW'(m_i[ADJ_IDX[k][1]]);
        pc1_a_r[k] <= PW'(m_i[ADJ_IDX[k][2]]) * PW'(m_i[ADJ_IDX[k][3]]);
        ps_a_r[k]  <= PW'(m_i[k]) * PW'(m_i[TRN_IDX[k]]);
      end
    end
  end

  // Stage B: adjugate, trace of A*A, trace squared, reciprocal product for trace/3.
  t3ii_ctl_t              ctl_b_r;
  logic signed [D-1:0]    m_b_r [9];
  logic signed [AW-1:0]   adj_b_r [9];
  logic signed [SQW-1:0]  s_b_r;
  logic signed [SQW-1:0]  tt_b_r;
  logic signed [TW-1:0]   t_b_r;
  logic [XW+K-1:0]        dp_b_r;
  logic [XW-1:0]          x_b_r;
  logic                   tneg_b_r;
  logic signed [SQW-1:0]  s_nxt;
  logic [XW-1:0]          x_nxt;

  always_comb begin
    s_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      s_nxt = s_nxt + SQW'(ps_a_r[k]);
    end
    x_nxt = t_a_r[TW-1] ? XW'(-t_a_r) : XW'(t_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_b_r    <= m_a_r;
      s_b_r    <= s_nxt;
      tt_b_r   <= SQW'(t_a_r) * SQW'(t_a_r);
      t_b_r    <= t_a_r;
      dp_b_r   <= (XW+K)'(x_nxt) * (XW+K)'(M3);
      x_b_r    <= x_nxt;
      tneg_b_r <= t_a_r[TW-1];
      for (int k = 0; k < 9; k++) begin
        adj_b_r[k] <= AW'(pc0_a_r[k]) - AW'(pc1_a_r[k]);
      end
    end
  end

  // Stage C: second invariant and split products of row 0 with its cofactors.
  t3ii_ctl_t               ctl_c_r;
  logic signed [D-1:0]     m_c_r [9];
  logic signed [AW-1:0]    adj_c_r [9];
  logic signed [TW-1:0]    t_c_r;
  logic signed [I2W-1:0]   i2_c_r;
  logic signed [2*D:0]     dpl_c_r [3];
  logic signed [2*D:0]     dph_c_r [3];
  logic [XW-1:0]           q0_c_r;
  logic [XW-1:0]           x_c_r;
  logic                    tneg_c_r;
  logic signed [I2W-1:0]   i2_diff;

  assign i2_diff = I2W'(tt_b_r) - I2W'(s_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else if (en) begin
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_c_r    <= m_b_r;
      adj_c_r  <= adj_b_r;
      t_c_r    <= t_b_r;
      i2_c_r   <= i2_diff >>> (F + 1);
      q0_c_r   <= dp_b_r[XW+K-1:K];
      x_c_r    <= x_b_r;
      tneg_c_r <= tneg_b_r;
      for (int j = 0; j < 3; j++) begin
        dpl_c_r[j] <= (2*D+1)'(m_b_r[j]) *
                      (2*D+1)'($signed({1'b0, adj_b_r[3*j][D-1:0]}));
        dph_c_r[j] <= (2*D+1)'(m_b_r[j]) * (2*D+1)'($signed(adj_b_r[3*j][AW-1:D]));
      end
    end
  end

  // Stage D: determinant sum and corrected trace/3.
  t3ii_ctl_t               ctl_d_r;
  logic signed [D-1:0]     m_d_r [9];
  logic signed [AW-1:0]    adj_d_r [9];
  logic signed [TW-1:0]    t_d_r;
  logic signed [I2W-1:0]   i2_d_r;
  logic signed [DW-1:0]    det_d_r;
  logic signed [TW-1:0]    third_d_r;
  logic signed [DW-1:0]    det_nxt;
  logic [XW+1:0]           rem3;
  logic [XW-1:0]           q3;
  logic signed [TW-1:0]    q3x;

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'(dph_c_r[j]) <<< D) + DW'(dpl_c_r[j]);
    end
    rem3 = {2'b00, x_c_r} - ({1'b0, q0_c_r, 1'b0} + {2'b00, q0_c_r});
    q3   = q0_c_r + XW'(rem3 >= (XW+2)'(3));
    q3x  = $signed({1'b0, q3});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
    end else if (en) begin
      ctl_d_r <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_d_r     <= m_c_r;
      adj_d_r   <= adj_c_r;
      t_d_r     <= t_c_r;
      i2_d_r    <= i2_c_r;
      det_d_r   <= det_nxt;
      third_d_r <= tneg_c_r ? -q3x : q3x;
    end
  end

  // Stage E: magnitudes for the dividers and the saturated results of the other modes.
  logic [DW-1:0]          dabs_nxt;
  logic [CW-1:0]          rem_nxt [9];
  logic [8:0]             neg_nxt;
  logic [8:0]             qovf_nxt;
  logic [AW-1:0]          aabs;
  logic [D:0]             tr_s;
  logic [D:0]             i2_s;
  logic [D:0]             det_s;
  logic [D:0]             dev_s [9];
  logic signed [D-1:0]    alt_nxt [9];
  logic                   altovf_nxt;

  always_comb begin
    dabs_nxt = det_d_r[DW-1] ? DW'(-det_d_r) : DW'(det_d_r);
    for (int k = 0; k < 9; k++) begin
      aabs        = adj_d_r[k][AW-1] ? AW'(-adj_d_r[k]) : AW'(adj_d_r[k]);
      rem_nxt[k]  = CW'(aabs) << (2 * F);
      qovf_nxt[k] = rem_nxt[k] >= (CW'(dabs_nxt) << D);
      neg_nxt[k]  = adj_d_r[k][AW-1] ^ det_d_r[DW-1];
      if (k == 0 || k == 4 || k == 8) begin
        dev_s[k] = sat_d(WW'(TW'(m_d_r[k]) - third_d_r));
      end else begin
        dev_s[k] = {1'b0, m_d_r[k]};
      end
    end
    tr_s  = sat_d(WW'(t_d_r));
    i2_s  = sat_d(WW'(i2_d_r));
    det_s = sat_d(WW'(det_d_r >>> (2 * F)));

    altovf_nxt = 1'b0;
    for (int k = 0; k < 9; k++) begin
      alt_nxt[k] = '0;
    end
    case (ctl_d_r.mode)
      MODE_INVAR: begin
        alt_nxt[0] = tr_s[D-1:0];
        alt_nxt[1] = i2_s[D-1:0];
        alt_nxt[2] = det_s[D-1:0];
        altovf_nxt = tr_s[D] | i2_s[D] | det_s[D];
      end
      MODE_DEVIA: begin
        for (int k = 0; k < 9; k++) begin
          alt_nxt[k] = dev_s[k][D-1:0];
          altovf_nxt = altovf_nxt | dev_s[k][D];
        end
      end
      default: begin
        altovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o    <= rem_nxt;
      neg_o    <= neg_nxt;
      qovf_o   <= qovf_nxt;
      sing_o   <= (det_d_r == '0);
      dabs_o   <= dabs_nxt;
      alt_o    <= alt_nxt;
      altovf_o <= altovf_nxt;
    end
  end

endmodule

[rtl/t3ii_div_step.sv]
// One restoring division stage: nine lanes each decide one quotient bit.
// Depends on t3ii_pkg.
module t3ii_div_step #(
  parameter int D     = 32,
  parameter int CW    = 131,
  parameter int DW    = 99,
  parameter int SW    = 308,
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  t3ii_pkg::t3ii_ctl_t ctl_i,
  input  logic [CW-1:0]       rem_i [9],
  input  logic [D-1:0]        q_i [9],
  input  logic [DW-1:0]       dabs_i,
  input  logic [SW-1:0]       side_i,
  output t3ii_pkg::t3ii_ctl_t ctl_o,
  output logic [CW-1:0]       rem_o [9],
  output logic [D-1:0]        q_o [9],
  output logic [DW-1:0]       dabs_o,
  output logic [SW-1:0]       side_o
);
  import t3ii_pkg::*;

  logic [CW:0]   diff [9];
  logic [CW-1:0] rem_nxt [9];
  logic [D-1:0]  q_nxt [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      diff[k]    = {1'b0, rem_i[k]} - {1'b0, CW'(dabs_i) << SHIFT};
      rem_nxt[k] = diff[k][CW] ? rem_i[k] : diff[k][CW-1:0];
      q_nxt[k]   = q_i[k];
      q_nxt[k][SHIFT] = ~diff[k][CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      q_o    <= q_nxt;
      dabs_o <= dabs_i;
      side_o <= side_i;
    end
  end

endmodule

[rtl/tensor3x3_invariants_inverse_unit.sv]
// Top level of the 3x3 tensor invariants, inverse and deviatoric unit.
// Depends on t3ii_pkg, t3ii_front and t3ii_div_step.
//
// This unit takes one 3x3 matrix of signed fixed-point entries (FRAC_BITS fraction bits
// in DATA_WIDTH bits) and a mode each cycle, and returns one result item per matrix in
// order. Mode 0 gives the trace, the second invariant and the determinant in the first
// three slots; mode 1 gives the inverse, with singular raised and zeros returned for a
// zero determinant; mode 2 gives the deviatoric part. Every value is clamped to the
// DATA_WIDTH signed range and overflow is raised when any value was clamped. The unit is
// fully pipelined and accepts a new item in every cycle while the output is not stalled.
// Each item passes through five front-end stages (products, adjugate, second invariant,
// determinant, operand preparation), then DATA_WIDTH stages of restoring division, each
// deciding one quotient bit in all nine inverse lanes, then the output register. When the
// output item is stalled the whole pipeline holds, so in_stall follows out_stall while a
// result is waiting.
module tensor3x3_invariants_inverse_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_a_00,
  input  logic signed [DATA_WIDTH-1:0] in_a_01,
  input  logic signed [DATA_WIDTH-1:0] in_a_02,
  input  logic signed [DATA_WIDTH-1:0] in_a_10,
  input  logic signed [DATA_WIDTH-1:0] in_a_11,
  input  logic signed [DATA_WIDTH-1:0] in_a_12,
  input  logic signed [DATA_WIDTH-1:0] in_a_20,
  input  logic signed [DATA_WIDTH-1:0] in_a_21,
  input  logic signed [DATA_WIDTH-1:0] in_a_22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_r_00,
  output logic signed [DATA_WIDTH-1:0] out_r_01,
  output logic signed [DATA_WIDTH-1:0] out_r_02,
  output logic signed [DATA_WIDTH-1:0] out_r_10,
  output logic signed [DATA_WIDTH-1:0] out_r_11,
  output logic signed [DATA_WIDTH-1:0] out_r_12,
  output logic signed [DATA_WIDTH-1:0] out_r_20,
  output logic signed [DATA_WIDTH-1:0] out_r_21,
  output logic signed [DATA_WIDTH-1:0] out_r_22,
  output logic                         out_singular,
  output logic                         out_overflow
);
  import t3ii_pkg::*;

  localparam int D  = DATA_WIDTH;
  localparam int AW = 2 * D + 1;
  localparam int DW = 3 * D + 3;
  localparam int NW = AW + 2 * FRAC_BITS;
  localparam int CW = (NW > DW + D) ? NW : DW + D;
  // Side band carried past the dividers: other-mode results, per-lane flags, then the item flags.
  localparam int SW = 9 * D + 20;
  localparam int NEG_LO  = 9 * D;
  localparam int QOVF_LO = 9 * D + 9;
  localparam int SING_B  = 9 * D + 18;
  localparam int AOVF_B  = 9 * D + 19;

  localparam logic signed [D-1:0] MAX_V = {1'b0, {(D-1){1'b1}}};
  localparam logic signed [D-1:0] MIN_V = {1'b1, {(D-1){1'b0}}};

  // The whole pipeline advances unless a finished item is held at the output.
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic signed [D-1:0] m_in [9];
  t3ii_ctl_t           ctl_in;

  assign m_in[0] = in_a_00;
  assign m_in[1] = in_a_01;
  assign m_in[2] = in_a_02;
  assign m_in[3] = in_a_10;
  assign m_in[4] = in_a_11;
  assign m_in[5] = in_a_12;
  assign m_in[6] = in_a_20;
  assign m_in[7] = in_a_21;
  assign m_in[8] = in_a_22;
  assign ctl_in.valid = in_valid;
  assign ctl_in.mode  = mode_t'(in_mode);

  // Front end.
  t3ii_ctl_t           ctl_f;
  logic [CW-1:0]       rem_f [9];
  logic [8:0]          neg_f;
  logic [8:0]          qovf_f;
  logic                sing_f;
  logic [DW-1:0]       dabs_f;
  logic signed [D-1:0] alt_f [9];
  logic                altovf_f;

  t3ii_front #(.D(D), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_i    (ctl_in),
    .m_i      (m_in),
    .ctl_o    (ctl_f),
    .rem_o    (rem_f),
    .neg_o    (neg_f),
    .qovf_o   (qovf_f),
    .sing_o   (sing_f),
    .dabs_o   (dabs_f),
    .alt_o    (alt_f),
    .altovf_o (altovf_f)
  );

  // Division chain: stage i decides quotient bit D-1-i of every lane.
  t3ii_ctl_t     ctl_s  [D+1];
  logic [CW-1:0] rem_s  [D+1][9];
  logic [D-1:0]  q_s    [D+1][9];
  logic [DW-1:0] dabs_s [D+1];
  logic [SW-1:0] side_s [D+1];

  assign ctl_s[0]  = ctl_f;
  assign rem_s[0]  = rem_f;
  assign dabs_s[0] = dabs_f;

  for (genvar k = 0; k < 9; k++) begin : g_side
    assign q_s[0][k]                  = '0;
    assign side_s[0][k*D +: D]        = alt_f[k];
    assign side_s[0][NEG_LO + k]      = neg_f[k];
    assign side_s[0][QOVF_LO + k]     = qovf_f[k];
  end
  assign side_s[0][SING_B] = sing_f;
  assign side_s[0][AOVF_B] = altovf_f;

  for (genvar i = 0; i < D; i++) begin : g_div
    t3ii_div_step #(
      .D     (D),
      .CW    (CW),
      .DW    (DW),
      .SW    (SW),
      .SHIFT (D - 1 - i)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .rem_i  (rem_s[i]),
      .q_i    (q_s[i]),
      .dabs_i (dabs_s[i]),
      .side_i (side_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .q_o    (q_s[i+1]),
      .dabs_o (dabs_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  // Sign, clamping and mode selection ahead of the output register.
  logic [SW-1:0]       side_l;
  logic [D-1:0]        q_l;
  logic                neg_l;
  logic signed [D-1:0] inv_v [9];
  logic [8:0]          inv_ovf;
  logic signed [D-1:0] res_nxt [9];
  logic                sing_nxt;
  logic                ovf_nxt;

  assign side_l = side_s[D];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      q_l   = q_s[D][k];
      neg_l = side_l[NEG_LO + k];
      if (side_l[QOVF_LO + k]) begin
        // Quotient magnitude beyond the quotient register: clamp by sign.
        inv_v[k]   = neg_l ? MIN_V : MAX_V;
        inv_ovf[k] = 1'b1;
      end else if (neg_l) begin
        inv_ovf[k] = q_l[D-1] && (|q_l[D-2:0]);
        inv_v[k]   = inv_ovf[k] ? MIN_V : $signed(D'(0) - q_l);
      end else begin
        inv_ovf[k] = q_l[D-1];
        inv_v[k]   = inv_ovf[k] ? MAX_V : $signed(q_l);
      end
    end

    sing_nxt = 1'b0;
    ovf_nxt  = side_l[AOVF_B];
    for (int k = 0; k < 9; k++) begin
      res_nxt[k] = side_l[k*D +: D];
    end
    case (ctl_s[D].mode)
      MODE_INVERSE: begin
        if (side_l[SING_B]) begin
          sing_nxt = 1'b1;
          ovf_nxt  = 1'b0;
          for (int k = 0; k < 9; k++) begin
            res_nxt[k] = '0;
          end
        end else begin
          ovf_nxt = |inv_ovf;
          for (int k = 0; k < 9; k++) begin
            res_nxt[k] = inv_v[k];
          end
        end
      end
      default: begin
        sing_nxt = 1'b0;
      end
    endcase
  end

  // Output register.
  logic signed [D-1:0] res_r [9];
  logic                sing_r;
  logic                ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[D].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sing_r <= sing_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_r_00     = res_r[0];
  assign out_r_01     = res_r[1];
  assign out_r_02     = res_r[2];
  assign out_r_10     = res_r[3];
  assign out_r_11     = res_r[4];
  assign out_r_12     = res_r[5];
  assign out_r_20     = res_r[6];
  assign out_r_21     = res_r[7];
  assign out_r_22     = res_r[8];
  assign out_singular = sing_r;
  assign out_overflow = ovf_r;

endmodule

[sim/tensor3x3_invariants_inverse_unit_tb.sv]
// Self-checking testbench for tensor3x3_invariants_inverse_unit: directed table, then random matrices.
// Depends on t3ii_pkg and the RTL; expectations are typed in or from an exact wide-integer predictor.
`timescale 1ns / 100ps

module tensor3x3_invariants_inverse_unit_tb;
  import t3ii_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1580;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;

  typedef logic signed [31:0] mat_t [9];
  // Wide enough for every intermediate: triple products and the shifted adjugate need ~100 bits.
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] r [9];
    logic singular;
    logic overflow;
  } tensor_res_t;

  typedef struct {
    logic [1:0] mode;
    mat_t a;
    bit typed;
    tensor_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_INVAR;
  logic signed [31:0] in_a [9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r [9];
  logic out_singular, out_overflow;

  // The row being offered, and whether its result was typed in by hand.
  bit cur_typed = 1'b0;
  tensor_res_t cur_res;

  tensor_res_t pending_results [$];
  row_t directed_rows [$];
  bit in_took = 1'b0;
  bit calm = 1'b0;
  bit done = 1'b0;
  int idle_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int mode_count [4] = '{default: 0};
  int singular_seen = 0;
  int overflow_seen = 0;

  always #6 clk = ~clk;

  tensor3x3_invariants_inverse_unit #(.DATA_WIDTH(32), .FRAC_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_a_00(in_a[0]), .in_a_01(in_a[1]), .in_a_02(in_a[2]),
    .in_a_10(in_a[3]), .in_a_11(in_a[4]), .in_a_12(in_a[5]),
    .in_a_20(in_a[6]), .in_a_21(in_a[7]), .in_a_22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_00(out_r[0]), .out_r_01(out_r[1]), .out_r_02(out_r[2]),
    .out_r_10(out_r[3]), .out_r_11(out_r[4]), .out_r_12(out_r[5]),
    .out_r_20(out_r[6]), .out_r_21(out_r[7]), .out_r_22(out_r[8]),
    .out_singular(out_singular), .out_overflow(out_overflow)
  );

  function automatic wide_t widen(logic signed [31:0] v);
    return {{224{v[31]}}, v};
  endfunction

  // Clamps to the Q16.16 range and notes whether clamping happened.
  function automatic logic signed [31:0] clamp_q(wide_t x, inout logic ovf);
    if (x > widen(Q_MAX)) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (x < widen(Q_MIN)) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return x[31:0];
  endfunction

  // Exact arithmetic on wide signed integers; only the final values are clamped.
  function automatic tensor_res_t predict_tensor(logic [1:0] mode, mat_t a);
    wide_t m [9];
    wide_t r [9];
    wide_t t, det, s, third;
    tensor_res_t res;
    for (int k = 0; k < 9; k++) begin
      m[k] = widen(a[k]);
      r[k] = '0;
    end
    res.singular = 1'b0;
    res.overflow = 1'b0;
    t = m[0] + m[4] + m[8];
    det = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
        - m[2]*m[4]*m[6] - m[0]*m[5]*m[7] - m[1]*m[3]*m[8];
    case (mode)
      MODE_INVAR: begin
        s = '0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) s = s + m[3*i+j] * m[3*j+i];
        r[0] = t;
        // Halving and the fixed-point rescale fold into one arithmetic shift.
        r[1] = (t * t - s) >>> 17;
        r[2] = det >>> 32;
      end
      MODE_INVERSE: begin
        if (det == 0) begin
          res.singular = 1'b1;
        end else begin
          r[0] = (m[4]*m[8] - m[5]*m[7]) <<< 32;
          r[1] = (m[2]*m[7] - m[1]*m[8]) <<< 32;
          r[2] = (m[1]*m[5] - m[2]*m[4]) <<< 32;
          r[3] = (m[5]*m[6] - m[3]*m[8]) <<< 32;
          r[4] = (m[0]*m[8] - m[2]*m[6]) <<< 32;
          r[5] = (m[2]*m[3] - m[0]*m[5]) <<< 32;
          r[6] = (m[3]*m[7] - m[4]*m[6]) <<< 32;
          r[7] = (m[1]*m[6] - m[0]*m[7]) <<< 32;
          r[8] = (m[0]*m[4] - m[1]*m[3]) <<< 32;
          // Signed division in SystemVerilog truncates toward zero, as required.
          for (int k = 0; k < 9; k++) r[k] = r[k] / det;
        end
      end
      MODE_DEVIA: begin
        third = t / widen(32'sd3);
        for (int k = 0; k < 9; k++) r[k] = (k % 4 == 0) ? m[k] - third : m[k];
      end
      default: ;
    endcase
    for (int k = 0; k < 9; k++) res.r[k] = clamp_q(r[k], res.overflow);
    return res;
  endfunction

  function automatic mat_t mat_fill(logic signed [31:0] on_diag, logic signed [31:0] off_diag);
    mat_t m;
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? on_diag : off_diag;
    return m;
  endfunction

  function automatic tensor_res_t res_mk(mat_t r, logic sing, logic ovf);
    tensor_res_t res;
    res.r = r;
    res.singular = sing;
    res.overflow = ovf;
    return res;
  endfunction

  // Random matrices of several flavours: raw noise, modest values around unity, tiny values of at
  // most 32 LSBs, entries near the limits, and rank-deficient ones whose last row repeats the first.
  function automatic mat_t rand_mat();
    mat_t m;
    int flavour;
    flavour = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (flavour)
        0, 1: m[k] = $urandom;
        2, 3, 4, 5: m[k] = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        6: m[k] = ($urandom_range(0, 1) ? Q_MAX : Q_MIN) ^ $urandom_range(0, 255);
        7: m[k] = $signed($urandom_range(0, 64)) - 32'sd32;
        default: m[k] = $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
      endcase
    end
    if (flavour >= 8)
      for (int k = 0; k < 3; k++) m[6 + k] = m[k];
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic add_row(logic [1:0] mode, mat_t a, bit typed, tensor_res_t res);
    row_t row;
    row.mode = mode;
    row.a = a;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the item was taken, with
  // in_valid still high so that back-to-back items see no gap.
  task automatic send_item(logic [1:0] mode, mat_t a, bit typed, tensor_res_t res);
    in_mode = mode;
    in_a = a;
    cur_typed = typed;
    cur_res = res;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_took);
    mode_count[mode]++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // All sampling happens here at the rising edge: the taken input item is turned into an
  // expectation before the output side is checked, so the order within the step is fixed.
  always @(posedge clk) begin
    tensor_res_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took)
      pending_results.push_back(cur_typed ? cur_res : predict_tensor(in_mode, in_a));
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_singular) singular_seen++;
      if (out_overflow) overflow_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding", results_seen, 0);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_r[k] !== want.r[k])
            report_mismatch($sformatf("r_%0d%0d", k / 3, k % 3), out_r[k], want.r[k]);
        if (out_singular !== want.singular)
          report_mismatch("singular", out_singular, want.singular);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
    if (in_took || (rst_n && out_valid && !out_stall) || !rst_n || done)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // The receiver stalls in random bursts, with stretches of none, and never in the calm tail.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  initial begin
    mat_t zero_m, ident, res_m;
    tensor_res_t none;
    zero_m = mat_fill('0, '0);
    ident = mat_fill(Q_ONE, '0);
    none = res_mk(zero_m, 1'b0, 1'b0);

    // Directed table. Rows with a hand-typed result are the ones that can be read off directly;
    // the others go through the predictor.
    add_row(MODE_INVAR, zero_m, 1, none);
    add_row(MODE_INVERSE, zero_m, 1, res_mk(zero_m, 1'b1, 1'b0));
    add_row(MODE_DEVIA, zero_m, 1, none);
    res_m = zero_m;
    res_m[0] = 32'sh30000;
    res_m[1] = 32'sh30000;
    res_m[2] = Q_ONE;
    add_row(MODE_INVAR, ident, 1, res_mk(res_m, 1'b0, 1'b0));
    add_row(MODE_INVERSE, ident, 1, res_mk(ident, 1'b0, 1'b0));
    add_row(MODE_DEVIA, ident, 1, none);
    add_row(MODE_INVERSE, mat_fill(32'sh20000, '0), 1,
            res_mk(mat_fill(32'sh8000, '0), 1'b0, 1'b0));
    // A rank-one matrix is singular.
    add_row(MODE_INVERSE, mat_fill(Q_ONE, Q_ONE), 1, res_mk(zero_m, 1'b1, 1'b0));
    // Determinant too small to show in the invariants, yet not singular: its inverse clamps.
    add_row(MODE_INVERSE, mat_fill(32'sd1, '0), 1,
            res_mk(mat_fill(Q_MAX, '0), 1'b0, 1'b1));
    // Negative values round toward minus infinity in the invariants.
    res_m = zero_m;
    res_m[0] = -32'sd3;
    res_m[2] = -32'sd1;
    add_row(MODE_INVAR, mat_fill(-32'sd1, '0), 1, res_mk(res_m, 1'b0, 1'b0));
    // A negative trace below three units truncates toward zero when divided by three.
    res_m = zero_m;
    res_m[0] = -32'sd1;
    add_row(MODE_DEVIA, res_m, 1, res_mk(res_m, 1'b0, 1'b0));
    // The unused mode returns nothing whatever the entries.
    add_row(MODE_UNUSED, mat_fill(Q_MAX, Q_MIN), 1, none);
    add_row(MODE_DEVIA, mat_fill(Q_MAX, '0), 1, none);
    for (int md = 0; md < 3; md++) begin
      add_row(md[1:0], mat_fill(Q_MAX, Q_MAX), 0, none);
      add_row(md[1:0], mat_fill(Q_MIN, Q_MIN), 0, none);
      add_row(md[1:0], mat_fill(32'shaaaaaaaa, 32'sh55555555), 0, none);
    end
    add_row(MODE_INVERSE, mat_fill(Q_MIN, Q_MAX), 0, none);
    add_row(MODE_INVAR, mat_fill(32'sh55555555, 32'shaaaaaaaa), 0, none);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      sender_gap();
      send_item(directed_rows[i].mode, directed_rows[i].a, directed_rows[i].typed,
                directed_rows[i].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      logic [1:0] mode;
      int pick;
      // Drain once completely so the sender sees an empty pipeline mid-run.
      if (n == RANDOM_ITEMS / 2) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      calm = (n >= RANDOM_ITEMS - 200);
      pick = $urandom_range(0, 30);
      mode = (pick == 30) ? MODE_UNUSED : pick[1:0] == 2'd3 ? MODE_INVERSE : pick[1:0];
      sender_gap();
      send_item(mode, rand_mat(), 0, none);
    end
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    done = 1'b1;
    repeat (60) @(negedge clk);

    $display("items per mode (invariants/inverse/deviatoric/unused): %0d %0d %0d %0d",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d results checked, %0d singular, %0d clamped, %0d mismatches",
             results_seen, singular_seen, overflow_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/t3ii_pkg.sv
rtl/t3ii_front.sv
rtl/t3ii_div_step.sv
rtl/tensor3x3_invariants_inverse_unit.sv
sim/tensor3x3_invariants_inverse_unit_tb.sv
